// File: src/cdo_pkg.sv
`timescale 1ns / 1ps
package cdo_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_SUB  = 2'd2;

   localparam logic [13:0] YEAR_MIN = 14'd1;
   localparam logic [13:0] YEAR_MAX = 14'd9999;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] MonthLen [13] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // reciprocal of 25 scaled by 2^22, exact for x below 7989
   localparam int unsigned RecipShift = 22;
   localparam logic [17:0] Recip25 = 18'd167773;

   typedef struct packed {
      logic [1:0]  op;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [15:0] count;
   } walk_req_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        err;
   } walk_rsp_type;

   function automatic logic div_by_25(input logic [11:0] x);
      logic [29:0] prod;
      logic [7:0]  q;
      logic [12:0] back;
      prod = 30'(x) * 30'(Recip25);
      q    = prod[29:RecipShift];
      back = 13'(q) * 13'(25);
      return back == {1'b0, x};
   endfunction

   function automatic logic is_leap(input logic [13:0] y);
      logic m4;
      logic m100;
      logic m400;
      m4   = (y[1:0] == 2'd0);
      m100 = m4 && div_by_25(y[13:2]);
      m400 = (y[3:0] == 4'd0) && div_by_25({2'b0, y[13:4]});
      return (m4 && !m100) || m400;
   endfunction

   function automatic logic [4:0] month_length(input logic [13:0] y, input logic [3:0] m);
      logic [4:0] n;
      n = 5'd0;
      if (m >= MONTH_JAN && m <= MONTH_DEC) begin
         n = MonthLen[m];
         if (m == MONTH_FEB && is_leap(y)) begin
            n = n + 5'd1;
         end
      end
      return n;
   endfunction

endpackage

// File: src/cdo_walk.sv
`timescale 1ns / 1ps
module cdo_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start_valid,
   output logic                  start_ready,
   input  cdo_pkg::walk_req_type start_req,
   input  logic [13:0]           cur_year,
   input  logic [3:0]            cur_month,
   input  logic [4:0]            cur_day,
   output logic                  done_valid,
   input  logic                  done_ready,
   output cdo_pkg::walk_rsp_type done_rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [13:0]        y_ff, y_in;
   logic [3:0]         m_ff, m_in;
   logic signed [17:0] d_ff, d_in;
   logic               err_ff, err_in;

   logic [4:0] mlen_cur;
   logic [4:0] mlen_prev;
   logic       load_bad;

   // lengths of the running month and of the month before it, and whether a loaded date is invalid
   always_comb begin
      mlen_cur  = cdo_pkg::month_length(y_ff, m_ff);
      mlen_prev = (m_ff == cdo_pkg::MONTH_JAN) ?
                  cdo_pkg::month_length(y_ff, cdo_pkg::MONTH_DEC) :
                  cdo_pkg::month_length(y_ff, m_ff - 4'd1);
      load_bad  = (y_ff < cdo_pkg::YEAR_MIN) || (y_ff > cdo_pkg::YEAR_MAX) ||
                  (mlen_cur == 5'd0) || (d_ff < 18'sd1) ||
                  (d_ff > $signed({13'b0, mlen_cur}));
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      d_in     = d_ff;
      err_in   = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_valid) begin
               state_in = ST_RUN;
               op_in    = start_req.op;
               err_in   = 1'b0;
               if (start_req.op == cdo_pkg::OP_LOAD) begin
                  y_in = start_req.year;
                  m_in = start_req.month;
                  d_in = $signed({13'b0, start_req.day});
               end else begin
                  y_in = cur_year;
                  m_in = cur_month;
                  if (start_req.op == cdo_pkg::OP_ADD) begin
                     d_in = $signed(18'({13'b0, cur_day}) + 18'({2'b0, start_req.count}));
                  end else begin
                     d_in = $signed(18'({13'b0, cur_day}) - 18'({2'b0, start_req.count}));
                  end
               end
            end
         end
         ST_RUN: begin
            unique case (op_ff)
               cdo_pkg::OP_LOAD: begin
                  err_in   = load_bad;
                  state_in = ST_DONE;
               end
               cdo_pkg::OP_ADD: begin
                  if (d_ff > $signed({13'b0, mlen_cur})) begin
                     d_in = d_ff - $signed({13'b0, mlen_cur});
                     if (m_ff == cdo_pkg::MONTH_DEC) begin
                        m_in = cdo_pkg::MONTH_JAN;
                        y_in = y_ff + 14'd1;
                        if (y_ff >= cdo_pkg::YEAR_MAX) begin
                           err_in   = 1'b1;
                           state_in = ST_DONE;
                        end
                     end else begin
                        m_in = m_ff + 4'd1;
                     end
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               cdo_pkg::OP_SUB: begin
                  if (d_ff <= 18'sd0) begin
                     d_in = d_ff + $signed({13'b0, mlen_prev});
                     if (m_ff == cdo_pkg::MONTH_JAN) begin
                        m_in = cdo_pkg::MONTH_DEC;
                        if (y_ff <= cdo_pkg::YEAR_MIN) begin
                           err_in   = 1'b1;
                           state_in = ST_DONE;
                        end else begin
                           y_in = y_ff - 14'd1;
                        end
                     end else begin
                        m_in = m_ff - 4'd1;
                     end
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
      end
      op_ff <= op_in;
      y_ff  <= y_in;
      m_ff  <= m_in;
      d_ff  <= d_in;
   end

   assign start_ready    = (state_ff == ST_IDLE);
   assign done_valid     = (state_ff == ST_DONE);
   assign done_rsp.year  = y_ff;
   assign done_rsp.month = m_ff;
   assign done_rsp.day   = d_ff[4:0];
   assign done_rsp.err   = err_ff;

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start_valid && start_ready |=> state_ff == ST_RUN)
      else $error("walk did not start after accept");

   a_month_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && op_ff != cdo_pkg::OP_LOAD |->
      m_ff >= cdo_pkg::MONTH_JAN && m_ff <= cdo_pkg::MONTH_DEC)
      else $error("month left range during walk");

   a_day_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !err_ff |-> d_ff >= 18'sd1 && d_ff <= 18'sd31)
      else $error("finished day out of range");

endmodule

// File: src/calendar_date_day_offset.sv
`timescale 1ns / 1ps
// a load or an unused opcode passes the walk unit's run and done states, then the output
// register; add and subtract stay in the run state for each month crossed (up to about 2160)
// one item at a time: the walk unit accepts again only once
// its result has moved to the output register, so a waiting result holds the input
// reset (synchronous, active high) sets the held date to 0001-01-01 and empties
// the result register
module calendar_date_day_offset (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [13:0] req_load_year,
   input  logic [3:0]  req_load_month,
   input  logic [4:0]  req_load_day,
   input  logic [15:0] req_day_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic        rsp_error_flag
);

   // held date
   logic [13:0] cur_year_ff, cur_year_in;
   logic [3:0]  cur_month_ff, cur_month_in;
   logic [4:0]  cur_day_ff, cur_day_in;

   // result register parts the walk from the consumer
   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] rsp_year_ff, rsp_year_in;
   logic [3:0]  rsp_month_ff, rsp_month_in;
   logic [4:0]  rsp_day_ff, rsp_day_in;
   logic        rsp_err_ff, rsp_err_in;

   cdo_pkg::walk_req_type walk_req;
   cdo_pkg::walk_rsp_type walk_rsp;
   logic                  walk_done_valid;
   logic                  walk_done_ready;
   logic                  walk_finish;

   assign walk_req.op    = req_opcode;
   assign walk_req.year  = req_load_year;
   assign walk_req.month = req_load_month;
   assign walk_req.day   = req_load_day;
   assign walk_req.count = req_day_count;

   // walk may hand over when the result slot is empty or draining
   assign walk_done_ready = !rsp_valid_ff || rsp_ready;
   assign walk_finish     = walk_done_valid && walk_done_ready;

   cdo_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_valid),
      .start_ready (req_ready),
      .start_req   (walk_req),
      .cur_year    (cur_year_ff),
      .cur_month   (cur_month_ff),
      .cur_day     (cur_day_ff),
      .done_valid  (walk_done_valid),
      .done_ready  (walk_done_ready),
      .done_rsp    (walk_rsp)
   );

   always_comb begin
      cur_year_in  = cur_year_ff;
      cur_month_in = cur_month_ff;
      cur_day_in   = cur_day_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (walk_finish) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = walk_rsp.err;
         if (walk_rsp.err) begin
            // rejected item: report the date that is kept
            rsp_year_in  = cur_year_ff;
            rsp_month_in = cur_month_ff;
            rsp_day_in   = cur_day_ff;
         end else begin
            cur_year_in  = walk_rsp.year;
            cur_month_in = walk_rsp.month;
            cur_day_in   = walk_rsp.day;
            rsp_year_in  = walk_rsp.year;
            rsp_month_in = walk_rsp.month;
            rsp_day_in   = walk_rsp.day;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_year_ff  <= cdo_pkg::YEAR_MIN;
         cur_month_ff <= cdo_pkg::MONTH_JAN;
         cur_day_ff   <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_year_ff  <= cur_year_in;
         cur_month_ff <= cur_month_in;
         cur_day_ff   <= cur_day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_year   = rsp_year_ff;
   assign rsp_out_month  = rsp_month_ff;
   assign rsp_out_day    = rsp_day_ff;
   assign rsp_error_flag = rsp_err_ff;

   // held date always stays a real calendar month
   a_held_month: assert property (@(posedge clock) disable iff (reset)
      cur_month_ff >= cdo_pkg::MONTH_JAN && cur_month_ff <= cdo_pkg::MONTH_DEC)
      else $error("held month out of range");

   // a rejected item never moves the held date (the check covers year and day)
   a_err_keeps_date: assert property (@(posedge clock) disable iff (reset)
      walk_finish && walk_rsp.err |=> $stable(cur_year_ff) && $stable(cur_day_ff))
      else $error("held date changed on rejected item");

   // a result never overwrites one still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !walk_finish)
      else $error("result register overrun");

endmodule
